@@ rtl/gcd_pkg.sv @@
// Shared constants, tables and helpers for the great circle distance block.
// No dependencies; used by gcd_sincos and great_circle_distance.
`default_nettype none

package gcd_pkg;

	// fixed-point formats
	localparam int ANGLE_FRAC_BITS = 20;
	localparam int DIST_FRAC_BITS  = 8;
	localparam int CORDIC_STAGES   = 24;

	// datapath widths
	localparam int CW          = 34;  // CORDIC x/y/z width, Q2.30 with headroom
	localparam int TRIG_W      = 32;  // sine/cosine result width
	localparam int SQRT_STEPS  = 31;  // restoring root steps for a 61-bit radicand
	localparam int SQRT_W      = 62;
	localparam int DIST_W      = 23;

	// scale constants
	localparam logic [31:0] DEG_TO_TURN_K = 32'd3054198966;
	localparam logic [32:0] TURN_TO_RAD_K = 33'd6746518852;
	localparam logic [CW-1:0] HALF_PI_Q30  = CW'(1686629713);
	localparam logic [CW-1:0] GAIN_INV_Q30 = CW'(652032874);
	localparam logic [28:0] RADIUS_Q16    = 29'd418014036;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	// arctangent of 2^-i, Q2.30 radians
	localparam logic [31:0] ATAN_Q30 [32] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
		32'h00000001, 32'h00000000
	};

	// fixed-point degrees to binary angle, 2^32 per turn
	function automatic logic [31:0] deg_to_turn(input logic signed [63:0] d);
		logic signed [63:0] p;
		p = d * $signed({32'd0, DEG_TO_TURN_K});
		return p[ANGLE_FRAC_BITS+39:ANGLE_FRAC_BITS+8];
	endfunction

endpackage

`default_nettype wire

@@ rtl/gcd_sincos.sv @@
// Pipelined rotation-mode CORDIC: binary angle in, sine and cosine out (Q2.30).
// Depends on gcd_pkg. Registered in and out; all stages advance when en is high.
`default_nettype none

module gcd_sincos (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   en,
	input  wire  [31:0]                           turn,
	output logic signed [gcd_pkg::TRIG_W-1:0]     sin_v,
	output logic signed [gcd_pkg::TRIG_W-1:0]     cos_v
);

	localparam int N  = gcd_pkg::CORDIC_STAGES;
	localparam int CW = gcd_pkg::CW;

	logic               flip;
	logic signed [31:0] a;
	logic [30:0]        mag;
	logic [63:0]        rad_p;

	logic signed [CW-1:0] x_s [0:N];
	logic signed [CW-1:0] y_s [0:N];
	logic signed [CW-1:0] z_s [0:N];
	logic                 flip_s [0:N];

	// fold second and third quadrants by a half turn, then scale to radians
	always_comb begin
		flip  = turn[31] ^ turn[30];
		a     = $signed({turn[31] ^ flip, turn[30:0]});
		mag   = a[31] ? 31'(-a) : a[30:0];
		rad_p = 64'(mag) * 64'(gcd_pkg::TURN_TO_RAD_K);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= gcd_pkg::GAIN_INV_Q30;
			y_s[0]    <= '0;
			z_s[0]    <= a[31] ? -$signed(CW'(rad_p[63:32])) : $signed(CW'(rad_p[63:32]));
			flip_s[0] <= flip;
		end
	end

	// one micro-rotation per stage
	for (genvar i = 0; i < N; i++) begin : g_rot
		localparam logic signed [CW-1:0] ATAN = CW'(gcd_pkg::ATAN_Q30[i]);
		always_ff @(posedge clk) begin
			if (en) begin
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ATAN;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ATAN;
				end
				flip_s[i+1] <= flip_s[i];
			end
		end
	end

	// undo the half-turn fold
	always_ff @(posedge clk) begin
		if (en) begin
			sin_v <= flip_s[N] ? gcd_pkg::TRIG_W'(-y_s[N]) : gcd_pkg::TRIG_W'(y_s[N]);
			cos_v <= flip_s[N] ? gcd_pkg::TRIG_W'(-x_s[N]) : gcd_pkg::TRIG_W'(x_s[N]);
		end
	end

	// arst_n kept for a uniform port list; this datapath holds payload only
	logic unused_rst;
	assign unused_rst = arst_n;

endmodule

`default_nettype wire

@@ rtl/great_circle_distance.sv @@
// Great circle distance between two points, spherical law of cosines.
//
// Input stream s_*: one beat carries two points as fixed-point degrees.
// Output stream m_*: one beat per input beat, distance in km with
// DIST_FRAC_BITS fraction bits, saturating at the 23-bit maximum.
// Pipe stages in order: deg-to-turn multiply, sine/cosine CORDIC,
// four product and clamp stages, a 31-step root, the arccosine
// CORDIC, the radius multiply and the output register.
// Throughput is one beat per cycle. The whole pipe moves on one enable
// that is high when the output register is empty or being taken, so a
// stall on m_tready freezes every stage and s_tready drops with it;
// nothing is lost or repeated. Reset clears the valid bits only; after
// reset the block is empty and ready.
// Depends on gcd_pkg and gcd_sincos.
`default_nettype none

module great_circle_distance (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [119:0] s_tdata,   // lat_a[27:0], lon_a[56:28], lat_b[84:57], lon_b[113:85]
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [23:0]  m_tdata    // distance_km[22:0]
);

	localparam int N   = gcd_pkg::CORDIC_STAGES;
	localparam int CW  = gcd_pkg::CW;
	localparam int TW  = gcd_pkg::TRIG_W;
	localparam int SQN = gcd_pkg::SQRT_STEPS;
	localparam int SW  = gcd_pkg::SQRT_W;
	localparam int LAT = 1 + (N + 2) + 4 + SQN + 1 + N + 2;
	localparam int RND = 45 - gcd_pkg::DIST_FRAC_BITS;

	logic en;
	logic [LAT-1:0] valid_q;

	assign en       = m_tready | ~m_tvalid;
	assign s_tready = en;
	assign m_tvalid = valid_q[LAT-1];

	// valid bits follow the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[LAT-2:0], s_tvalid};
		end
	end

	// stage 1: degrees to binary angle
	logic [31:0] ta_s1, oa_s1, tb_s1, ob_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			ta_s1 <= gcd_pkg::deg_to_turn(64'($signed(s_tdata[27:0])));
			oa_s1 <= gcd_pkg::deg_to_turn(64'($signed(s_tdata[56:28])));
			tb_s1 <= gcd_pkg::deg_to_turn(64'($signed(s_tdata[84:57])));
			ob_s1 <= gcd_pkg::deg_to_turn(64'($signed(s_tdata[113:85])));
		end
	end

	logic [31:0] td;
	assign td = ob_s1 - oa_s1;

	// sines and cosines
	logic signed [TW-1:0] sa, ca, sb, cb, sd, cd;
	gcd_sincos u_sc_a (.clk, .arst_n, .en, .turn(ta_s1), .sin_v(sa), .cos_v(ca));
	gcd_sincos u_sc_b (.clk, .arst_n, .en, .turn(tb_s1), .sin_v(sb), .cos_v(cb));
	gcd_sincos u_sc_d (.clk, .arst_n, .en, .turn(td),    .sin_v(sd), .cos_v(cd));

	// product stages and clamp of the arccosine argument
	logic signed [63:0]  sasb_s2, cacb_s2;
	logic signed [TW-1:0] cd_s2;
	logic signed [33:0]  sab_s3;
	logic signed [65:0]  cc_s3;
	logic signed [31:0]  cl_s4;
	logic signed [36:0]  csum;

	// root pipeline; entry 0 is the stage 5 register
	logic [SW-1:0]      sq_rem_s [0:SQN];
	logic [SW-1:0]      sq_res_s [0:SQN];
	logic signed [31:0] sq_c_s   [0:SQN];

	assign csum = 37'(sab_s3) + 37'(cc_s3 >>> 30);

	always_ff @(posedge clk) begin
		if (en) begin
			sasb_s2 <= 64'(sa) * 64'(sb);
			cacb_s2 <= 64'(ca) * 64'(cb);
			cd_s2   <= cd;
			sab_s3  <= 34'(sasb_s2 >>> 30);
			cc_s3   <= 66'($signed(34'(cacb_s2 >>> 30))) * 66'(cd_s2);
			if (csum > 37'sd1073741824)
				cl_s4 <= 32'sd1073741824;
			else if (csum < -37'sd1073741824)
				cl_s4 <= -32'sd1073741824;
			else
				cl_s4 <= 32'(csum);
			sq_rem_s[0] <= (SW'(1) << 60) - SW'(64'(cl_s4) * 64'(cl_s4));
			sq_res_s[0] <= '0;
			sq_c_s[0]   <= cl_s4;
		end
	end

	// restoring square root, one result bit per stage
	for (genvar j = 0; j < SQN; j++) begin : g_sqrt
		localparam logic [SW-1:0] BIT = SW'(1) << (60 - 2 * j);
		logic [SW-1:0] trial;
		assign trial = sq_res_s[j] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (sq_rem_s[j] >= trial) begin
					sq_rem_s[j+1] <= sq_rem_s[j] - trial;
					sq_res_s[j+1] <= (sq_res_s[j] >> 1) + BIT;
				end else begin
					sq_rem_s[j+1] <= sq_rem_s[j];
					sq_res_s[j+1] <= sq_res_s[j] >> 1;
				end
				sq_c_s[j+1] <= sq_c_s[j];
			end
		end
	end

	// arccosine by vectoring; start in the right half plane
	logic signed [CW-1:0] vx_s [0:N];
	logic signed [CW-1:0] vy_s [0:N];
	logic signed [CW-1:0] vz_s [0:N];
	logic signed [CW-1:0] root;

	assign root = $signed(CW'(sq_res_s[SQN][30:0]));

	always_ff @(posedge clk) begin
		if (en) begin
			if (sq_c_s[SQN] < 0) begin
				vx_s[0] <= root;
				vy_s[0] <= -CW'(sq_c_s[SQN]);
				vz_s[0] <= gcd_pkg::HALF_PI_Q30;
			end else begin
				vx_s[0] <= CW'(sq_c_s[SQN]);
				vy_s[0] <= root;
				vz_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_vec
		localparam logic signed [CW-1:0] ATAN = CW'(gcd_pkg::ATAN_Q30[i]);
		always_ff @(posedge clk) begin
			if (en) begin
				if (vy_s[i] > 0) begin
					vx_s[i+1] <= vx_s[i] + (vy_s[i] >>> i);
					vy_s[i+1] <= vy_s[i] - (vx_s[i] >>> i);
					vz_s[i+1] <= vz_s[i] + ATAN;
				end else begin
					vx_s[i+1] <= vx_s[i] - (vy_s[i] >>> i);
					vy_s[i+1] <= vy_s[i] + (vx_s[i] >>> i);
					vz_s[i+1] <= vz_s[i] - ATAN;
				end
			end
		end
	end

	// scale by the radius, round and saturate
	logic [32:0] zpos;
	logic [61:0] dprod_s;
	logic [61:0] drnd;

	assign zpos = vz_s[N][CW-1] ? 33'd0 : vz_s[N][32:0];
	assign drnd = (dprod_s + (62'(1) << RND)) >> (RND + 1);

	always_ff @(posedge clk) begin
		if (en) begin
			dprod_s <= 62'(zpos) * 62'(gcd_pkg::RADIUS_Q16);
			if (drnd > 62'(gcd_pkg::DIST_MAX))
				m_tdata <= {1'b0, gcd_pkg::DIST_MAX};
			else
				m_tdata <= {1'b0, drnd[gcd_pkg::DIST_W-1:0]};
		end
	end

	// pad bits of the input beat are not used
	logic unused_pad;
	assign unused_pad = ^s_tdata[119:114];

endmodule

`default_nettype wire
